// File: src/text_console_cell_buffer_unit_assert.svh
// assertion macros for the text console cell buffer
// all properties are sampled on clk and muted while rst_n is low
`ifndef TEXT_CONSOLE_CELL_BUFFER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CELL_BUFFER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCCB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication
`define TCCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// File: src/tccb_pkg.sv
package tccb_pkg;

    // action codes
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [7:0] SPACE_CHAR   = 8'd32;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SWEEP
    } state_t;

endpackage

// File: src/text_console_cell_buffer_unit.sv
// text console cell buffer: a ROWS x COLUMNS grid of character bytes plus a
// cursor. start is taken at a clock edge where busy is low. a put writes the
// character at the cursor at the accepting edge; characters past the end
// of a row are dropped, newline (10) goes to column 0 of the next row. a
// newline on the last row scrolls: the grid is addressed through a rotating
// top-row pointer, so scrolling only moves that pointer and blanks the new
// bottom row, which keeps busy high while it is blanked. a clear blanks
// every cell and homes the cursor, busy while it runs; the same clearing
// pass runs after reset before the first item is taken. a read item is
// busy while it is in the read state, and its result is on cell_char,
// pixel_x and pixel_y for exactly one cycle with result_valid; the read
// passes the memory's registered read port, then the output registers.
// the receiver cannot stall: results must be captured when result_valid is
// high. a read outside the grid returns a space with the pixel position
// still computed. action 3 is accepted and ignored.
module text_console_cell_buffer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  character,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_column,
    input  logic [10:0] origin_x,
    input  logic [10:0] origin_y,
    output logic        result_valid,
    output logic [7:0]  cell_char,
    output logic [11:0] pixel_x,
    output logic [11:0] pixel_y
);

    // column field of the cell address covers a power-of-two span of columns
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CCW   = $clog2(COLUMNS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS << CW;

    tccb_pkg::state_t state_reg, state_next;

    logic [RW-1:0]  top_reg, top_next;             // physical row shown as row 0
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [CCW-1:0] cur_col_reg, cur_col_next;     // COLUMNS means row full
    logic [RW-1:0]  sweep_row_reg, sweep_row_next;
    logic [RW-1:0]  sweep_end_reg, sweep_end_next;
    logic [CW-1:0]  sweep_col_reg, sweep_col_next;
    logic           result_valid_reg, result_valid_next;

    logic           in_grid_reg, in_grid_next;
    logic [7:0]     cell_char_reg, cell_char_next;
    logic [11:0]    pixel_x_reg, pixel_x_next;
    logic [11:0]    pixel_y_reg, pixel_y_next;

    logic           accept;
    logic           is_newline;
    logic           row_full;
    logic           last_row;
    logic           sweep_done;

    // shared row adder
    logic [RW-1:0]  add_a;
    logic [RW-1:0]  add_b;
    logic [RW-1:0]  row_sum;

    // cell memory port
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    assign accept     = start && !busy;
    assign is_newline = (character == tccb_pkg::NEWLINE_CHAR);
    assign row_full   = (cur_col_reg >= CCW'(COLUMNS));
    assign last_row   = (cur_row_reg == RW'(ROWS - 1));
    assign sweep_done = (sweep_col_reg == CW'(COLUMNS - 1)) && (sweep_row_reg == sweep_end_reg);

    tccb_row_add #(
        .ROWS (ROWS),
        .RW   (RW)
    ) u_row_add (
        .a   (add_a),
        .b   (add_b),
        .sum (row_sum)
    );

    tccb_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tccb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        tccb_pkg::ACT_READ:  state_next = tccb_pkg::S_READ;
                        tccb_pkg::ACT_CLEAR: state_next = tccb_pkg::S_SWEEP;
                        tccb_pkg::ACT_PUT:
                        begin
                            if (is_newline && last_row)
                            begin
                                state_next = tccb_pkg::S_SWEEP;
                            end
                        end
                        default: state_next = tccb_pkg::S_IDLE;
                    endcase
                end
            end
            tccb_pkg::S_READ:  state_next = tccb_pkg::S_IDLE;
            tccb_pkg::S_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = tccb_pkg::S_IDLE;
                end
            end
            default: state_next = tccb_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake, adder operands, memory port
    always_comb
    begin
        busy      = (state_reg != tccb_pkg::S_IDLE);
        add_a     = top_reg;
        add_b     = cur_row_reg;
        ram_we    = 1'b0;
        ram_wdata = character;
        ram_addr  = {row_sum, CW'(read_column)};
        unique case (state_reg)
            tccb_pkg::S_SWEEP:
            begin
                add_a     = sweep_row_reg;
                add_b     = RW'(1);
                ram_we    = 1'b1;
                ram_wdata = tccb_pkg::SPACE_CHAR;
                ram_addr  = {sweep_row_reg, sweep_col_reg};
            end
            tccb_pkg::S_IDLE:
            begin
                if (action == tccb_pkg::ACT_READ)
                begin
                    add_b = RW'(read_row);
                end
                else if (is_newline)
                begin
                    add_b = RW'(1);      // top + 1 on scroll
                end
                if (accept && (action == tccb_pkg::ACT_PUT) && !is_newline && !row_full)
                begin
                    ram_we   = 1'b1;
                    ram_addr = {row_sum, CW'(cur_col_reg)};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        top_next          = top_reg;
        cur_row_next      = cur_row_reg;
        cur_col_next      = cur_col_reg;
        sweep_row_next    = sweep_row_reg;
        sweep_end_next    = sweep_end_reg;
        sweep_col_next    = sweep_col_reg;
        result_valid_next = 1'b0;
        in_grid_next      = in_grid_reg;
        cell_char_next    = cell_char_reg;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        unique case (state_reg)
            tccb_pkg::S_SWEEP:
            begin
                if (sweep_col_reg == CW'(COLUMNS - 1))
                begin
                    sweep_col_next = '0;
                    sweep_row_next = row_sum;
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + CW'(1);
                end
            end
            tccb_pkg::S_READ:
            begin
                cell_char_next    = in_grid_reg ? ram_rdata : tccb_pkg::SPACE_CHAR;
                result_valid_next = 1'b1;
            end
            tccb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        tccb_pkg::ACT_READ:
                        begin
                            in_grid_next = (int'(read_row) < ROWS) &&
                                           (int'(read_column) < COLUMNS);
                            pixel_x_next = {1'b0, origin_x} + {2'b00, read_column, 3'b000};
                            pixel_y_next = {1'b0, origin_y} + {3'b000, read_row, 4'b0000};
                        end
                        tccb_pkg::ACT_CLEAR:
                        begin
                            top_next       = '0;
                            cur_row_next   = '0;
                            cur_col_next   = '0;
                            sweep_row_next = '0;
                            sweep_end_next = RW'(ROWS - 1);
                            sweep_col_next = '0;
                        end
                        tccb_pkg::ACT_PUT:
                        begin
                            if (is_newline)
                            begin
                                cur_col_next = '0;
                                if (last_row)
                                begin
                                    // old top row becomes the blank bottom row
                                    top_next       = row_sum;
                                    sweep_row_next = top_reg;
                                    sweep_end_next = top_reg;
                                    sweep_col_next = '0;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + RW'(1);
                                end
                            end
                            else if (!row_full)
                            begin
                                cur_col_next = cur_col_reg + CCW'(1);
                            end
                        end
                        default:
                        begin
                            in_grid_next = in_grid_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    // control registers, reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tccb_pkg::S_SWEEP;
            top_reg          <= '0;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            sweep_row_reg    <= '0;
            sweep_end_reg    <= RW'(ROWS - 1);
            sweep_col_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            top_reg          <= top_next;
            cur_row_reg      <= cur_row_next;
            cur_col_reg      <= cur_col_next;
            sweep_row_reg    <= sweep_row_next;
            sweep_end_reg    <= sweep_end_next;
            sweep_col_reg    <= sweep_col_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_grid_reg   <= in_grid_next;
        cell_char_reg <= cell_char_next;
        pixel_x_reg   <= pixel_x_next;
        pixel_y_reg   <= pixel_y_next;
    end

    assign result_valid = result_valid_reg;
    assign cell_char    = cell_char_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;

endmodule

// File: src/tccb_cell_ram.sv
module tccb_cell_ram #(
    parameter int DEPTH = 3200,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tccb_row_add.sv
module tccb_row_add #(
    parameter int ROWS = 25,
    parameter int RW   = 5
) (
    input  logic [RW-1:0] a,
    input  logic [RW-1:0] b,
    output logic [RW-1:0] sum
);

    logic [RW:0] raw;

    // modulo-ROWS add, one conditional subtract
    always_comb
    begin
        raw = {1'b0, a} + {1'b0, b};
        if (raw >= (RW+1)'(ROWS))
        begin
            raw = raw - (RW+1)'(ROWS);
        end
        sum = raw[RW-1:0];
    end

endmodule

// File: src/tccb_checker.sv
`include "text_console_cell_buffer_unit_assert.svh"

module tccb_checker #(
    parameter int COLUMNS = 80
) (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] action,
    input logic [6:0] read_column,
    input logic       result_valid,
    input logic [7:0] cell_char
);

    logic read_accept;

    assign read_accept = start && !busy && (action == tccb_pkg::ACT_READ);

    `TCCB_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe held two cycles")
    `TCCB_ASSERT_SAME(a_read_result, read_accept, ##2 result_valid, "read item gave no result")
    `TCCB_ASSERT_SAME(a_result_origin, result_valid, $past(read_accept, 2), "result without a read")
    `TCCB_ASSERT_SAME(a_outside_space, read_accept && (int'(read_column) >= COLUMNS), ##2 (cell_char == tccb_pkg::SPACE_CHAR), "read outside grid not a space")

endmodule

bind text_console_cell_buffer_unit tccb_checker #(
    .COLUMNS (COLUMNS)
) u_tccb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .read_column  (read_column),
    .result_valid (result_valid),
    .cell_char    (cell_char)
);
